// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the cost assembly RTL.
// Depends on nothing; users supply clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LSCA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LSCA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lsca_pkg.sv =====
// Shared constants, codes and types of the least-squares cost assembly.
// No dependencies; used by lsca_ctrl, lsca_datapath and the top level.
package lsca_pkg;

    localparam int TASK_DIM  = 18;
    localparam int MAT_DEPTH = TASK_DIM * TASK_DIM;
    localparam int MAT_AW    = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;
    localparam int VEC_AW    = (TASK_DIM > 1) ? $clog2(TASK_DIM) : 1;

    localparam int IDX_W     = 5;
    localparam int REQ_W     = 3;
    localparam int VAL_W     = 32;
    localparam int ACC_W     = 64;
    localparam int FRAC_W    = 16;
    localparam int RND_W     = ACC_W - FRAC_W + 1;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 64;

    // request codes carried in s_tuser
    localparam logic [REQ_W-1:0] REQ_WR_JAC  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_WR_RATE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_WR_VEL  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_WR_ACC  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_RD_MAT  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_RD_LIN  = 3'd5;

    // datapath operations, one issued per cycle at most
    typedef enum logic [2:0] {
        OP_NONE,
        OP_GRAM,    // acc += J[k][i] * J[k][j]
        OP_BKI,     // bk  = xa[k] << 16
        OP_RATE,    // bk -= Jd[k][m] * qd[m]
        OP_ROUND,   // b16 = round(bk)
        OP_LIN      // acc -= J[k][i] * b16
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GRAM,
        ST_BKI,
        ST_LINP,
        ST_RATE,
        ST_ROUND,
        ST_DRAIN,
        ST_LLAST,
        ST_FLUSH,
        ST_DONE
    } state_t;

    typedef struct packed {
        op_t               op;
        logic              clear;
        logic              load_out;
        logic              wr_en;
        logic [REQ_W-1:0]  wr_sel;
        logic [MAT_AW-1:0] wr_mat_addr;
        logic [VEC_AW-1:0] wr_vec_addr;
        logic [MAT_AW-1:0] ja_addr;
        logic [MAT_AW-1:0] jb_addr;
        logic [MAT_AW-1:0] jd_addr;
        logic [VEC_AW-1:0] qd_addr;
        logic [VEC_AW-1:0] xa_addr;
    } cmd_t;

endpackage

// ===== rtl/lsca_ctrl.sv =====
// Sequencer of the cost assembly: handshakes, loop counters, op issue.
// Depends on lsca_pkg and assert_macros.svh; drives lsca_datapath via cmd.
`include "assert_macros.svh"

module lsca_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lsca_pkg::REQ_W-1:0]    req_type,
    input  logic [lsca_pkg::IDX_W-1:0]    row_index,
    input  logic [lsca_pkg::IDX_W-1:0]    column_index,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output lsca_pkg::cmd_t                cmd
);

    lsca_pkg::state_t state_reg, state_next;

    logic [lsca_pkg::VEC_AW-1:0] k_reg, k_next;
    logic [lsca_pkg::VEC_AW-1:0] m_reg, m_next;
    logic [lsca_pkg::MAT_AW-1:0] base_reg, base_next;
    logic [lsca_pkg::MAT_AW-1:0] prev_base_reg, prev_base_next;
    logic [lsca_pkg::VEC_AW-1:0] row_reg, row_next;
    logic [lsca_pkg::VEC_AW-1:0] col_reg, col_next;
    logic                        flush_reg, flush_next;
    logic                        out_vld_reg, out_vld_next;

    logic row_ok, col_ok, k_last, m_last, out_free;

    assign row_ok   = {1'b0, row_index} < (lsca_pkg::IDX_W + 1)'(lsca_pkg::TASK_DIM);
    assign col_ok   = {1'b0, column_index} < (lsca_pkg::IDX_W + 1)'(lsca_pkg::TASK_DIM);
    assign k_last   = k_reg == lsca_pkg::VEC_AW'(lsca_pkg::TASK_DIM - 1);
    assign m_last   = m_reg == lsca_pkg::VEC_AW'(lsca_pkg::TASK_DIM - 1);
    assign out_free = !out_vld_reg || m_tready;

    assign s_tready = state_reg == lsca_pkg::ST_IDLE;
    assign m_tvalid = out_vld_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lsca_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    priority if (req_type == lsca_pkg::REQ_RD_MAT)
                        state_next = (row_ok && col_ok) ? lsca_pkg::ST_GRAM : lsca_pkg::ST_DONE;
                    else if (req_type == lsca_pkg::REQ_RD_LIN)
                        state_next = row_ok ? lsca_pkg::ST_BKI : lsca_pkg::ST_DONE;
                    else
                        state_next = lsca_pkg::ST_IDLE;
                end
            end
            lsca_pkg::ST_GRAM:
            begin
                if (k_last)
                    state_next = lsca_pkg::ST_FLUSH;
            end
            lsca_pkg::ST_BKI:
                state_next = (k_reg == '0) ? lsca_pkg::ST_RATE : lsca_pkg::ST_LINP;
            lsca_pkg::ST_LINP:
                state_next = lsca_pkg::ST_RATE;
            lsca_pkg::ST_RATE:
            begin
                if (m_last)
                    state_next = lsca_pkg::ST_ROUND;
            end
            lsca_pkg::ST_ROUND:
                state_next = k_last ? lsca_pkg::ST_DRAIN : lsca_pkg::ST_BKI;
            lsca_pkg::ST_DRAIN:
                state_next = lsca_pkg::ST_LLAST;
            lsca_pkg::ST_LLAST:
                state_next = lsca_pkg::ST_FLUSH;
            lsca_pkg::ST_FLUSH:
            begin
                if (flush_reg)
                    state_next = lsca_pkg::ST_DONE;
            end
            lsca_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = lsca_pkg::ST_IDLE;
            end
            default:
                state_next = lsca_pkg::ST_IDLE;
        endcase
    end

    // commands and loop counters
    always_comb
    begin
        cmd            = '0;
        cmd.op         = lsca_pkg::OP_NONE;
        k_next         = k_reg;
        m_next         = m_reg;
        base_next      = base_reg;
        prev_base_next = prev_base_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        flush_next     = 1'b0;

        cmd.wr_sel      = req_type;
        cmd.wr_mat_addr = lsca_pkg::MAT_AW'(row_index * lsca_pkg::TASK_DIM + column_index);
        cmd.wr_vec_addr = row_index[lsca_pkg::VEC_AW-1:0];

        unique case (state_reg)
            lsca_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    row_next       = row_index[lsca_pkg::VEC_AW-1:0];
                    col_next       = column_index[lsca_pkg::VEC_AW-1:0];
                    k_next         = '0;
                    m_next         = '0;
                    base_next      = '0;
                    prev_base_next = '0;
                    priority if (req_type == lsca_pkg::REQ_WR_JAC ||
                                 req_type == lsca_pkg::REQ_WR_RATE)
                        cmd.wr_en = row_ok && col_ok;
                    else if (req_type == lsca_pkg::REQ_WR_VEL ||
                             req_type == lsca_pkg::REQ_WR_ACC)
                        cmd.wr_en = row_ok;
                    else if (req_type == lsca_pkg::REQ_RD_MAT ||
                             req_type == lsca_pkg::REQ_RD_LIN)
                        cmd.clear = 1'b1;
                    else
                        cmd.wr_en = 1'b0;
                end
            end
            lsca_pkg::ST_GRAM:
            begin
                cmd.op      = lsca_pkg::OP_GRAM;
                cmd.ja_addr = base_reg + lsca_pkg::MAT_AW'(row_reg);
                cmd.jb_addr = base_reg + lsca_pkg::MAT_AW'(col_reg);
                if (!k_last)
                begin
                    k_next    = k_reg + lsca_pkg::VEC_AW'(1);
                    base_next = base_reg + lsca_pkg::MAT_AW'(lsca_pkg::TASK_DIM);
                end
            end
            lsca_pkg::ST_BKI:
            begin
                cmd.op      = lsca_pkg::OP_BKI;
                cmd.xa_addr = k_reg;
                m_next      = '0;
            end
            lsca_pkg::ST_LINP:
            begin
                // linear step of the previous row, its b16 is settled by now
                cmd.op      = lsca_pkg::OP_LIN;
                cmd.ja_addr = prev_base_reg + lsca_pkg::MAT_AW'(row_reg);
            end
            lsca_pkg::ST_RATE:
            begin
                cmd.op      = lsca_pkg::OP_RATE;
                cmd.jd_addr = base_reg + lsca_pkg::MAT_AW'(m_reg);
                cmd.qd_addr = m_reg;
                if (!m_last)
                    m_next = m_reg + lsca_pkg::VEC_AW'(1);
            end
            lsca_pkg::ST_ROUND:
            begin
                cmd.op = lsca_pkg::OP_ROUND;
                if (!k_last)
                begin
                    k_next         = k_reg + lsca_pkg::VEC_AW'(1);
                    prev_base_next = base_reg;
                    base_next      = base_reg + lsca_pkg::MAT_AW'(lsca_pkg::TASK_DIM);
                end
            end
            lsca_pkg::ST_DRAIN:
                cmd.op = lsca_pkg::OP_NONE;
            lsca_pkg::ST_LLAST:
            begin
                cmd.op      = lsca_pkg::OP_LIN;
                cmd.ja_addr = base_reg + lsca_pkg::MAT_AW'(row_reg);
            end
            lsca_pkg::ST_FLUSH:
                flush_next = ~flush_reg;
            lsca_pkg::ST_DONE:
                cmd.load_out = out_free;
            default:
                cmd.op = lsca_pkg::OP_NONE;
        endcase
    end

    assign out_vld_next = cmd.load_out ? 1'b1 : (m_tready ? 1'b0 : out_vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lsca_pkg::ST_IDLE;
            k_reg         <= '0;
            m_reg         <= '0;
            base_reg      <= '0;
            prev_base_reg <= '0;
            flush_reg     <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            m_reg         <= m_next;
            base_reg      <= base_next;
            prev_base_reg <= prev_base_next;
            flush_reg     <= flush_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
        col_reg <= col_next;
    end

    `LSCA_ASSERT_IMPL(a_no_overwrite, cmd.load_out && out_vld_reg, m_tready, "result overwritten")
    `LSCA_ASSERT_IMPL(a_linp_after_bki, state_reg == lsca_pkg::ST_LINP, $past(state_reg) == lsca_pkg::ST_BKI, "linear step out of order")
    `LSCA_ASSERT_IMPL(a_done_drained, state_reg == lsca_pkg::ST_DONE && $past(state_reg) != lsca_pkg::ST_DONE, $past(state_reg) == lsca_pkg::ST_FLUSH || $past(state_reg) == lsca_pkg::ST_IDLE, "result before drain")
    `LSCA_ASSERT_NEXT(a_round_last, state_reg == lsca_pkg::ST_ROUND && k_last, state_reg == lsca_pkg::ST_DRAIN, "last row not drained")

endmodule

// ===== rtl/lsca_datapath.sv =====
// Datapath of the cost assembly: operand stores, one shared multiplier,
// saturating accumulate, Q16.16 rounding and the result register.
// Depends on lsca_pkg; sequenced by lsca_ctrl through cmd.
module lsca_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  lsca_pkg::cmd_t                      cmd,
    input  logic signed [lsca_pkg::VAL_W-1:0]   write_value,
    output logic signed [lsca_pkg::ACC_W-1:0]   read_value,
    output logic                                saturated
);

    // operand stores
    logic signed [lsca_pkg::VAL_W-1:0] j_mem  [lsca_pkg::MAT_DEPTH];
    logic signed [lsca_pkg::VAL_W-1:0] jd_mem [lsca_pkg::MAT_DEPTH];
    logic signed [lsca_pkg::VAL_W-1:0] qd_mem [lsca_pkg::TASK_DIM];
    logic signed [lsca_pkg::VAL_W-1:0] xa_mem [lsca_pkg::TASK_DIM];

    // stage 1: registered reads
    logic signed [lsca_pkg::VAL_W-1:0] ja_reg, jb_reg, jd_reg, qd_reg, xa_reg;
    lsca_pkg::op_t                     op1_reg, op2_reg;

    // stage 2: product
    logic signed [lsca_pkg::VAL_W-1:0] mul_a, mul_b;
    logic signed [lsca_pkg::ACC_W-1:0] product;
    logic signed [lsca_pkg::ACC_W-1:0] prod_reg, prod_next;

    // stage 3: accumulate and round
    logic signed [lsca_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic signed [lsca_pkg::ACC_W-1:0] bk_reg, bk_next;
    logic signed [lsca_pkg::VAL_W-1:0] b16_reg, b16_next;
    logic                              sat_reg, sat_next;
    logic signed [lsca_pkg::ACC_W-1:0] lhs, sum, add_res;
    logic                              do_sub, add_ovf;
    logic signed [lsca_pkg::RND_W-1:0] q;
    logic                              rnd_ovf;
    logic signed [lsca_pkg::VAL_W-1:0] rnd_res;

    logic signed [lsca_pkg::ACC_W-1:0] out_data_reg;
    logic                              out_sat_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            unique case (cmd.wr_sel)
                lsca_pkg::REQ_WR_JAC:  j_mem[cmd.wr_mat_addr]  <= write_value;
                lsca_pkg::REQ_WR_RATE: jd_mem[cmd.wr_mat_addr] <= write_value;
                lsca_pkg::REQ_WR_VEL:  qd_mem[cmd.wr_vec_addr] <= write_value;
                lsca_pkg::REQ_WR_ACC:  xa_mem[cmd.wr_vec_addr] <= write_value;
                default: ;
            endcase
        end
        ja_reg <= j_mem[cmd.ja_addr];
        jb_reg <= j_mem[cmd.jb_addr];
        jd_reg <= jd_mem[cmd.jd_addr];
        qd_reg <= qd_mem[cmd.qd_addr];
        xa_reg <= xa_mem[cmd.xa_addr];
    end

    // operand select for the shared multiplier
    always_comb
    begin
        unique case (op1_reg)
            lsca_pkg::OP_GRAM:
            begin
                mul_a = ja_reg;
                mul_b = jb_reg;
            end
            lsca_pkg::OP_RATE:
            begin
                mul_a = jd_reg;
                mul_b = qd_reg;
            end
            lsca_pkg::OP_LIN:
            begin
                mul_a = ja_reg;
                mul_b = b16_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // signed 32x32, exact in 64 bits
    assign product = lsca_pkg::ACC_W'(mul_a) * lsca_pkg::ACC_W'(mul_b);

    // xa[k] in Q32.32 rides the product register
    assign prod_next = (op1_reg == lsca_pkg::OP_BKI) ?
        {{(lsca_pkg::ACC_W - lsca_pkg::VAL_W - lsca_pkg::FRAC_W){xa_reg[lsca_pkg::VAL_W-1]}},
         xa_reg, {lsca_pkg::FRAC_W{1'b0}}} : product;

    // saturating add/sub; overflow always lands on the sign of lhs
    assign do_sub  = (op2_reg == lsca_pkg::OP_RATE) || (op2_reg == lsca_pkg::OP_LIN);
    assign lhs     = (op2_reg == lsca_pkg::OP_RATE) ? bk_reg : acc_reg;
    assign sum     = do_sub ? (lhs - prod_reg) : (lhs + prod_reg);
    assign add_ovf = (do_sub ? (lhs[lsca_pkg::ACC_W-1] != prod_reg[lsca_pkg::ACC_W-1])
                             : (lhs[lsca_pkg::ACC_W-1] == prod_reg[lsca_pkg::ACC_W-1])) &&
                     (sum[lsca_pkg::ACC_W-1] != lhs[lsca_pkg::ACC_W-1]);
    assign add_res = !add_ovf ? sum :
                     (lhs[lsca_pkg::ACC_W-1] ? {1'b1, {(lsca_pkg::ACC_W-1){1'b0}}}
                                             : {1'b0, {(lsca_pkg::ACC_W-1){1'b1}}});

    // Q32.32 to Q16.16: floor shift plus the half bit, then clamp
    assign q = $signed({bk_reg[lsca_pkg::ACC_W-1], bk_reg[lsca_pkg::ACC_W-1:lsca_pkg::FRAC_W]}) +
               $signed({{(lsca_pkg::RND_W-1){1'b0}}, bk_reg[lsca_pkg::FRAC_W-1]});
    assign rnd_ovf = q[lsca_pkg::RND_W-1:lsca_pkg::VAL_W-1] !=
                     {(lsca_pkg::RND_W - lsca_pkg::VAL_W + 1){q[lsca_pkg::RND_W-1]}};
    assign rnd_res = !rnd_ovf ? q[lsca_pkg::VAL_W-1:0] :
                     (q[lsca_pkg::RND_W-1] ? {1'b1, {(lsca_pkg::VAL_W-1){1'b0}}}
                                           : {1'b0, {(lsca_pkg::VAL_W-1){1'b1}}});

    always_comb
    begin
        acc_next = acc_reg;
        bk_next  = bk_reg;
        b16_next = b16_reg;
        sat_next = sat_reg;
        unique case (op2_reg)
            lsca_pkg::OP_GRAM, lsca_pkg::OP_LIN:
            begin
                acc_next = add_res;
                sat_next = sat_reg | add_ovf;
            end
            lsca_pkg::OP_RATE:
            begin
                bk_next  = add_res;
                sat_next = sat_reg | add_ovf;
            end
            lsca_pkg::OP_BKI:
                bk_next = prod_reg;
            lsca_pkg::OP_ROUND:
            begin
                b16_next = rnd_res;
                sat_next = sat_reg | rnd_ovf;
            end
            default: ;
        endcase
        if (cmd.clear)
        begin
            acc_next = '0;
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op1_reg <= lsca_pkg::OP_NONE;
            op2_reg <= lsca_pkg::OP_NONE;
        end
        else
        begin
            op1_reg <= cmd.op;
            op2_reg <= op1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        bk_reg   <= bk_next;
        b16_reg  <= b16_next;
        sat_reg  <= sat_next;
        if (cmd.load_out)
        begin
            out_data_reg <= acc_reg;
            out_sat_reg  <= sat_reg;
        end
    end

    assign read_value = out_data_reg;
    assign saturated  = out_sat_reg;

endmodule

// ===== rtl/least_squares_cost_assembly_top.sv =====
// Top level of the least-squares cost assembly (Gram matrix and linear term).
// Depends on lsca_pkg, lsca_ctrl and lsca_datapath.
//
// channel  dir  beat contents
// -------  ---  -----------------------------------------------------------
// s_*      in   tuser: req_type; tdata: row_index, column_index, write_value
// m_*      out  tuser: saturated; tdata: read_value (one beat per read)
//
// Matrix reads issue one J-pair product per cycle through the shared
// multiplier, then drain the datapath pipeline. In linear reads each of the
// 18 rows needs one xa load, 18 Jd*qd steps on the single Jd read port, one
// rounding step and one J*b step; the Jd*qd and J*b steps share the one
// multiplier and the saturating adder.
// Reads with an index beyond the task return zero.
// Reset clears control only; stores hold garbage until written.
// A result waits in the output register while the next beat is accepted;
// a later read that finishes first holds until that register is taken.
module least_squares_cost_assembly_top
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [2:0] req_type
    input  logic [lsca_pkg::REQ_W-1:0]       s_tuser,
    // [4:0] row_index, [9:5] column_index, [41:10] write_value, [47:42] zero
    input  logic [lsca_pkg::S_TDATA_W-1:0]   s_tdata,

    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] saturated
    output logic                             m_tuser,
    // [63:0] read_value
    output logic [lsca_pkg::M_TDATA_W-1:0]   m_tdata
);

    lsca_pkg::cmd_t cmd;

    logic [lsca_pkg::IDX_W-1:0]        row_index;
    logic [lsca_pkg::IDX_W-1:0]        column_index;
    logic signed [lsca_pkg::VAL_W-1:0] write_value;
    logic signed [lsca_pkg::ACC_W-1:0] read_value;

    // unpack the input beat
    assign row_index    = s_tdata[lsca_pkg::IDX_W-1:0];
    assign column_index = s_tdata[2*lsca_pkg::IDX_W-1:lsca_pkg::IDX_W];
    assign write_value  = s_tdata[2*lsca_pkg::IDX_W+lsca_pkg::VAL_W-1:2*lsca_pkg::IDX_W];

    lsca_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .req_type     (s_tuser),
        .row_index    (row_index),
        .column_index (column_index),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .cmd          (cmd)
    );

    lsca_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .write_value (write_value),
        .read_value  (read_value),
        .saturated   (m_tuser)
    );

    assign m_tdata = read_value;

endmodule
